/* sv/rrcs_pkg.sv */
// Shared types and codes of the round-robin scheduler block.
package rrcs_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] EV_RUN    = 3'd0;
    localparam logic [2:0] EV_IDLE   = 3'd1;
    localparam logic [2:0] EV_DONE   = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_REJECT = 3'd4;

    localparam logic [9:0] QUANTUM_RESET = 10'd1;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } t_entry;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  slice_tag;
        logic [31:0] slice_start;
        logic [31:0] slice_end;
        logic        process_finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] total_waiting;
        logic [31:0] total_turnaround;
        logic [6:0]  process_count;
    } t_result;

    typedef struct packed {
        logic latch_in;
        logic clear;
        logic res_reject;
        logic res_done;
        logic ld_init;
        logic ld_rd;
        logic ld_shift;
        logic ld_write;
        logic set_started;
        logic scan_start;
        logic scan_min;
        logic scan_run;
        logic ring_rd;
        logic tbl_rd;
        logic run;
        logic finish;
        logic idle_res;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic full;
        logic loaded_zero;
        logic all_finished;
        logic ld_greater;
        logic ld_last;
        logic scan_done;
        logic ring_empty;
        logic out_free;
    } t_status;

endpackage

/* sv/rrcs_if.sv */
// Channel interfaces of the round-robin scheduler: request, result and configuration.
interface rrcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  process_tag;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    modport source (output valid, operation, process_tag, arrival_time, burst_time,
                    input ready);
    modport sink   (input valid, operation, process_tag, arrival_time, burst_time,
                    output ready);
endinterface

interface rrcs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  slice_tag;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic        process_finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] total_waiting;
    logic [31:0] total_turnaround;
    logic [6:0]  process_count;
    modport source (output valid, event_kind, slice_tag, slice_start, slice_end,
                    process_finished, turnaround, waiting, total_waiting,
                    total_turnaround, process_count, input ready);
    modport sink   (input valid, event_kind, slice_tag, slice_start, slice_end,
                    process_finished, turnaround, waiting, total_waiting,
                    total_turnaround, process_count, output ready);
endinterface

interface rrcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/round_robin_cpu_schedule.sv */
// Top level of the round-robin CPU scheduler block.
//
// Requests arrive on i_in: load (tag, arrival, burst), step, or clear. Every
// load, step and clear gives exactly one result on o_out; the unused code is
// dropped without a result. i_cfg writes the quantum at any time; it is
// always ready. Loads keep the process table sorted by arrival and are
// refused once stepping has begun or the table is full.
// The table memory has a single read port. A load walks the table from its
// end, shifting each entry with a later arrival past the new one, until an
// entry stops the walk or the start of the table is reached; a clear walks nothing.
// A step with a process to run makes two admission scans of the table, one
// before and one after the run slice; an idle gap makes one admission scan
// and one earliest-arrival scan; when everything has finished, a step scans
// nothing and gives the done result.
// One request is worked at a time; i_in.ready is high only while idle. The
// result sits in an output register, so a new request is accepted while it
// waits; a stalled receiver holds the next result until o_out is taken.
// Reset (synchronous, active low) empties the table and ring, zeroes the
// clock and totals and sets the quantum to 1; no clearing pass is needed.
module round_robin_cpu_schedule #(
    parameter int MAX_PROCS = 64
) (
    input logic    i_clk,
    input logic    i_rst_n,
    rrcs_in_if.sink    i_in,
    rrcs_out_if.source o_out,
    rrcs_cfg_if.sink   i_cfg
);
    import rrcs_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result res;
    logic    in_ready;

    // sequencer: owns the request handshake, drives the datapath
    rrcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // table, ring, totals and the output register
    rrcs_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_process_tag  (i_in.process_tag),
        .i_arrival_time (i_in.arrival_time),
        .i_burst_time   (i_in.burst_time),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_cfg_ready    (i_cfg.ready),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out          (res)
    );

    assign i_in.ready = in_ready;

    // spread the result register onto the channel fields
    assign o_out.event_kind       = res.event_kind;
    assign o_out.slice_tag        = res.slice_tag;
    assign o_out.slice_start      = res.slice_start;
    assign o_out.slice_end        = res.slice_end;
    assign o_out.process_finished = res.process_finished;
    assign o_out.turnaround       = res.turnaround;
    assign o_out.waiting          = res.waiting;
    assign o_out.total_waiting    = res.total_waiting;
    assign o_out.total_turnaround = res.total_turnaround;
    assign o_out.process_count    = res.process_count;

endmodule

/* sv/rrcs_ctrl.sv */
// Sequencer of the round-robin scheduler: decodes requests and steps the datapath.
module rrcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    output logic              o_in_ready,
    input  rrcs_pkg::t_status i_status,
    output rrcs_pkg::t_cmd    o_cmd
);
    import rrcs_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LD_CHK   = 4'd1;
    localparam logic [3:0] S_LD_RD    = 4'd2;
    localparam logic [3:0] S_LD_CMP   = 4'd3;
    localparam logic [3:0] S_LD_WR    = 4'd4;
    localparam logic [3:0] S_ST_CHK   = 4'd5;
    localparam logic [3:0] S_ADM1     = 4'd6;
    localparam logic [3:0] S_SEL      = 4'd7;
    localparam logic [3:0] S_MIN      = 4'd8;
    localparam logic [3:0] S_IDLE_RES = 4'd9;
    localparam logic [3:0] S_TBL_RD   = 4'd10;
    localparam logic [3:0] S_RUN      = 4'd11;
    localparam logic [3:0] S_ADM2     = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    case (i_operation)
                        OP_LOAD:  n_state = S_LD_CHK;
                        OP_STEP:  n_state = S_ST_CHK;
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_EMIT;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_CHK: begin
                if (i_status.started || i_status.full) begin
                    o_cmd.res_reject = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.ld_init = 1'b1;
                    n_state       = i_status.loaded_zero ? S_LD_WR : S_LD_RD;
                end
            end
            S_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = S_LD_CMP;
            end
            S_LD_CMP: begin
                if (i_status.ld_greater) begin
                    o_cmd.ld_shift = 1'b1;
                    n_state        = i_status.ld_last ? S_LD_WR : S_LD_RD;
                end else begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.ld_write = 1'b1;
                n_state        = S_EMIT;
            end
            S_ST_CHK: begin
                o_cmd.set_started = 1'b1;
                if (i_status.all_finished) begin
                    o_cmd.res_done = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_ADM1;
                end
            end
            S_ADM1: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (i_status.ring_empty) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_min   = 1'b1;
                    n_state          = S_MIN;
                end else begin
                    o_cmd.ring_rd = 1'b1;
                    n_state       = S_TBL_RD;
                end
            end
            S_MIN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_IDLE_RES;
                end
            end
            S_IDLE_RES: begin
                o_cmd.idle_res = 1'b1;
                n_state        = S_EMIT;
            end
            S_TBL_RD: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = S_RUN;
            end
            S_RUN: begin
                o_cmd.run        = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_ADM2;
            end
            S_ADM2: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* sv/rrcs_datapath.sv */
// Datapath of the round-robin scheduler: process table, ready ring, clock and totals.
module rrcs_datapath #(
    parameter int MAX_PROCS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrcs_pkg::t_cmd    i_cmd,
    output rrcs_pkg::t_status o_status,
    input  logic [7:0]        i_process_tag,
    input  logic [15:0]       i_arrival_time,
    input  logic [15:0]       i_burst_time,
    input  logic              i_cfg_valid,
    input  logic [9:0]        i_cfg_data,
    output logic              o_cfg_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rrcs_pkg::t_result o_out
);
    import rrcs_pkg::*;

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);
    localparam logic [CW-1:0] DEPTH    = CW'(MAX_PROCS);

    t_entry        mem_tbl [MAX_PROCS];
    logic [IW-1:0] mem_ring [MAX_PROCS];

    logic [9:0]           r_quantum;
    logic [7:0]           r_tag;
    logic [15:0]          r_arr;
    logic [15:0]          r_bur;
    logic [IW-1:0]        r_pos;
    t_entry               r_tbl_q;
    logic [IW-1:0]        r_ring_q;
    logic [MAX_PROCS-1:0] r_done;
    logic [MAX_PROCS-1:0] r_queued;
    logic [IW-1:0]        r_head;
    logic [IW-1:0]        r_tail;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_loaded;
    logic [CW-1:0]        r_finished;
    logic [31:0]          r_now;
    logic [31:0]          r_sumw;
    logic [31:0]          r_sumt;
    logic                 r_started;
    logic [CW-1:0]        r_scan_i;
    logic                 r_pv;
    logic [IW-1:0]        r_pidx;
    logic                 r_mode_min;
    logic [15:0]          r_min;
    logic                 r_any;
    logic [IW-1:0]        r_idx;
    logic [15:0]          r_cur_arr;
    logic [15:0]          r_cur_bur;
    logic [15:0]          r_cur_rem;
    t_result              r_res;
    t_result              n_res;
    t_result              r_out;
    logic                 r_out_valid;

    logic          scan_issue;
    logic          tbl_re;
    logic [IW-1:0] tbl_ra;
    logic          tbl_we;
    logic [IW-1:0] tbl_wa;
    t_entry        tbl_wd;
    logic          admit_hit;
    logic          min_hit;
    logic          push;
    logic [IW-1:0] push_idx;
    logic [9:0]    qv;
    logic [15:0]   run_len;
    logic [15:0]   new_rem;
    logic [31:0]   now_end;
    logic [31:0]   idle_next;
    logic [31:0]   tat;
    logic [31:0]   wt;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    assign scan_issue = i_cmd.scan_run && (r_scan_i < r_loaded);

    assign qv      = (r_quantum == '0) ? 10'd1 : r_quantum;
    assign run_len = (r_tbl_q.remaining < {6'd0, qv}) ? r_tbl_q.remaining : {6'd0, qv};
    assign new_rem = r_tbl_q.remaining - run_len;
    assign now_end = r_now + {16'd0, run_len};
    assign idle_next = (r_any && ({16'd0, r_min} >= r_now)) ? {16'd0, r_min} : r_now;
    assign tat     = r_now - {16'd0, r_cur_arr};
    assign wt      = tat - {16'd0, r_cur_bur};

    // scan evaluation of each entry, in the cycle after its table read
    assign admit_hit = r_pv && !r_mode_min && !r_done[r_pidx] && !r_queued[r_pidx]
                       && ({16'd0, r_tbl_q.arrival} <= r_now);
    assign min_hit   = r_pv && r_mode_min && !r_done[r_pidx]
                       && (!r_any || (r_tbl_q.arrival < r_min));

    assign push     = (admit_hit || (i_cmd.finish && (r_cur_rem != '0))) && (r_fill < DEPTH);
    assign push_idx = admit_hit ? r_pidx : r_idx;

    always_comb begin
        tbl_re = 1'b0;
        tbl_ra = r_ring_q;
        if (i_cmd.ld_rd) begin
            tbl_re = 1'b1;
            tbl_ra = r_pos - 1'b1;
        end else if (scan_issue) begin
            tbl_re = 1'b1;
            tbl_ra = r_scan_i[IW-1:0];
        end else if (i_cmd.tbl_rd) begin
            tbl_re = 1'b1;
        end
    end

    always_comb begin
        tbl_we = 1'b0;
        tbl_wa = r_pos;
        tbl_wd = r_tbl_q;
        if (i_cmd.ld_shift) begin
            tbl_we = 1'b1;
        end else if (i_cmd.ld_write) begin
            tbl_we = 1'b1;
            tbl_wd = '{tag: r_tag, arrival: r_arr, burst: r_bur, remaining: r_bur};
        end else if (i_cmd.run) begin
            tbl_we           = 1'b1;
            tbl_wa           = r_idx;
            tbl_wd.remaining = new_rem;
        end
    end

    // next result, built field by field
    always_comb begin
        n_res = r_res;
        if (i_cmd.clear || i_cmd.res_reject) begin
            n_res            = '0;
            n_res.event_kind = EV_REJECT;
        end else if (i_cmd.res_done) begin
            n_res                  = '0;
            n_res.event_kind       = EV_DONE;
            n_res.total_waiting    = r_sumw;
            n_res.total_turnaround = r_sumt;
            n_res.process_count    = 7'(r_loaded);
        end else if (i_cmd.ld_write) begin
            n_res               = '0;
            n_res.event_kind    = EV_ACCEPT;
            n_res.slice_tag     = r_tag;
            n_res.process_count = 7'(CW'(r_loaded + 1'b1));
        end else if (i_cmd.idle_res) begin
            n_res             = '0;
            n_res.event_kind  = EV_IDLE;
            n_res.slice_start = r_now;
            n_res.slice_end   = idle_next;
        end else if (i_cmd.run) begin
            n_res             = '0;
            n_res.event_kind  = EV_RUN;
            n_res.slice_tag   = r_tbl_q.tag;
            n_res.slice_start = r_now;
            n_res.slice_end   = now_end;
        end else if (i_cmd.finish && (r_cur_rem == '0)) begin
            n_res.process_finished = 1'b1;
            n_res.turnaround       = tat;
            n_res.waiting          = wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            mem_tbl[tbl_wa] <= tbl_wd;
        end
        if (tbl_re) begin
            r_tbl_q <= mem_tbl[tbl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem_ring[r_tail] <= push_idx;
        end
        if (i_cmd.ring_rd) begin
            r_ring_q <= mem_ring[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum   <= QUANTUM_RESET;
            r_done      <= '0;
            r_queued    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_now       <= '0;
            r_sumw      <= '0;
            r_sumt      <= '0;
            r_started   <= 1'b0;
            r_scan_i    <= '0;
            r_pv        <= 1'b0;
            r_mode_min  <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_data;
            end
            r_pv <= scan_issue;
            if (i_cmd.scan_start) begin
                r_scan_i   <= '0;
                r_mode_min <= i_cmd.scan_min;
                r_any      <= 1'b0;
            end else if (scan_issue) begin
                r_scan_i <= r_scan_i + 1'b1;
            end
            if (min_hit) begin
                r_any <= 1'b1;
            end
            if (admit_hit) begin
                r_queued[r_pidx] <= 1'b1;
            end
            if (push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (i_cmd.ring_rd) begin
                r_head <= wrap_inc(r_head);
                r_fill <= r_fill - 1'b1;
            end else if (push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.ld_write) begin
                r_loaded <= r_loaded + 1'b1;
            end
            if (i_cmd.set_started) begin
                r_started <= 1'b1;
            end
            if (i_cmd.idle_res) begin
                r_now <= idle_next;
            end
            if (i_cmd.run) begin
                r_now <= now_end;
            end
            if (i_cmd.finish && (r_cur_rem == '0)) begin
                r_done[r_idx] <= 1'b1;
                r_finished    <= r_finished + 1'b1;
                r_sumt        <= r_sumt + tat;
                r_sumw        <= r_sumw + wt;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_done     <= '0;
                r_queued   <= '0;
                r_head     <= '0;
                r_tail     <= '0;
                r_fill     <= '0;
                r_loaded   <= '0;
                r_finished <= '0;
                r_now      <= '0;
                r_sumw     <= '0;
                r_sumt     <= '0;
                r_started  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_tag <= i_process_tag;
            r_arr <= i_arrival_time;
            r_bur <= i_burst_time;
        end
        r_pidx <= r_scan_i[IW-1:0];
        if (min_hit) begin
            r_min <= r_tbl_q.arrival;
        end
        if (i_cmd.ld_init) begin
            r_pos <= r_loaded[IW-1:0];
        end else if (i_cmd.ld_shift) begin
            r_pos <= r_pos - 1'b1;
        end
        if (i_cmd.tbl_rd) begin
            r_idx <= r_ring_q;
        end
        if (i_cmd.run) begin
            r_cur_arr <= r_tbl_q.arrival;
            r_cur_bur <= r_tbl_q.burst;
            r_cur_rem <= new_rem;
        end
        r_res <= n_res;
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_status.started      = r_started;
    assign o_status.full         = (r_loaded >= DEPTH);
    assign o_status.loaded_zero  = (r_loaded == '0);
    assign o_status.all_finished = (r_finished >= r_loaded);
    assign o_status.ld_greater   = (r_tbl_q.arrival > r_arr);
    assign o_status.ld_last      = (r_pos == IW'(1));
    assign o_status.scan_done    = (r_scan_i >= r_loaded) && !r_pv;
    assign o_status.ring_empty   = (r_fill == '0);
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sv/rrcs_checker.sv */
// Port-level checks of the round-robin scheduler and their binding.
module rrcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_operation,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_event_kind,
    input logic       i_process_finished,
    input logic [31:0] i_slice_start,
    input logic [31:0] i_slice_end
);
    import rrcs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_operation != 2'd3) |=> !i_in_ready)
        else $error("request taken while busy");

    a_finish_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_process_finished |-> i_event_kind == EV_RUN)
        else $error("finish flag outside a run slice");

    a_idle_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_kind == EV_IDLE) |-> i_slice_end >= i_slice_start)
        else $error("idle gap runs backward");

endmodule

bind round_robin_cpu_schedule rrcs_checker u_rrcs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_operation        (i_in.operation),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_event_kind       (o_out.event_kind),
    .i_process_finished (o_out.process_finished),
    .i_slice_start      (o_out.slice_start),
    .i_slice_end        (o_out.slice_end)
);
